@@ rtl/core/hpq_pkg.sv @@
// Shared types and constants for the Huffman node priority queue.
package hpq_pkg;

    localparam int SYMBOL_BITS = 8;
    localparam int TAG_BITS    = 9;
    localparam int OUT_W_BITS  = 32;
    localparam int FILL_BITS   = 10;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // Per-cycle move applied to the whole row of cells.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP,
        OP_ROTATE
    } op_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic [TAG_BITS-1:0]    tag;
    } entry_t;

    typedef struct packed {
        op_t                    op;
        logic [SYMBOL_BITS-1:0] symbol;
        logic [TAG_BITS-1:0]    tag;
    } ctrl_t;

endpackage

@@ rtl/core/hpq_cell.sv @@
// One slot of the sorted row: holds an entry and trades it with its neighbors.
module hpq_cell #(
    parameter int WeightBits = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hpq_pkg::ctrl_t        ctrl,
    input  logic [WeightBits-1:0] new_weight,
    input  logic [WeightBits-1:0] left_weight,
    input  hpq_pkg::entry_t       left_entry,
    input  logic                  left_valid,
    input  logic                  left_open,
    input  logic [WeightBits-1:0] right_weight,
    input  hpq_pkg::entry_t       right_entry,
    input  logic                  right_valid,
    input  logic [WeightBits-1:0] head_weight,
    input  hpq_pkg::entry_t       head_entry,
    output logic [WeightBits-1:0] cell_weight,
    output hpq_pkg::entry_t       cell_entry,
    output logic                  cell_valid,
    output logic                  cell_open
);

    logic [WeightBits-1:0] weight_reg;
    logic [WeightBits-1:0] weight_next;
    hpq_pkg::entry_t       entry_reg;
    hpq_pkg::entry_t       entry_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  goes_before;

    // New entry sorts ahead of this one: lower weight, or same weight and higher symbol.
    assign goes_before = (new_weight < weight_reg)
                      || ((new_weight == weight_reg) && (ctrl.symbol > entry_reg.symbol));
    assign cell_open   = !valid_reg || goes_before;

    always_comb
    begin
        weight_next = weight_reg;
        entry_next  = entry_reg;
        valid_next  = valid_reg;
        unique case (ctrl.op)
            hpq_pkg::OP_INSERT:
            begin
                valid_next = valid_reg || left_valid;
                if (left_open)
                begin
                    weight_next = left_weight;
                    entry_next  = left_entry;
                end
                else if (cell_open)
                begin
                    weight_next = new_weight;
                    entry_next  = '{symbol: ctrl.symbol, tag: ctrl.tag};
                end
            end
            hpq_pkg::OP_POP:
            begin
                weight_next = right_weight;
                entry_next  = right_entry;
                valid_next  = right_valid;
            end
            hpq_pkg::OP_ROTATE:
            begin
                // last occupied slot receives the head, everyone else shifts left
                if (valid_reg && !right_valid)
                begin
                    weight_next = head_weight;
                    entry_next  = head_entry;
                end
                else
                begin
                    weight_next = right_weight;
                    entry_next  = right_entry;
                end
            end
            hpq_pkg::OP_HOLD:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
        entry_reg  <= entry_next;
    end

    assign cell_weight = weight_reg;
    assign cell_entry  = entry_reg;
    assign cell_valid  = valid_reg;

endmodule

@@ rtl/core/hpq_chain.sv @@
// Row of cells kept in sorted order; slot 0 holds the minimum.
module hpq_chain #(
    parameter int Capacity   = 512,
    parameter int WeightBits = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hpq_pkg::ctrl_t        ctrl,
    input  logic [WeightBits-1:0] new_weight,
    output logic [WeightBits-1:0] head_weight,
    output hpq_pkg::entry_t       head_entry
);

    logic [WeightBits-1:0] w_arr [Capacity];
    hpq_pkg::entry_t       e_arr [Capacity];
    logic                  v_arr [Capacity];
    logic                  o_arr [Capacity];

    assign head_weight = w_arr[0];
    assign head_entry  = e_arr[0];

    for (genvar i = 0; i < Capacity; i++)
    begin : g_cell
        logic [WeightBits-1:0] lw;
        hpq_pkg::entry_t       le;
        logic                  lv;
        logic                  lo;
        logic [WeightBits-1:0] rw;
        hpq_pkg::entry_t       re;
        logic                  rv;

        if (i == 0)
        begin : g_first
            assign lw = '0;
            assign le = '0;
            assign lv = 1'b1;
            assign lo = 1'b0;
        end
        else
        begin : g_mid_l
            assign lw = w_arr[i-1];
            assign le = e_arr[i-1];
            assign lv = v_arr[i-1];
            assign lo = o_arr[i-1];
        end

        if (i == Capacity - 1)
        begin : g_last
            assign rw = '0;
            assign re = '0;
            assign rv = 1'b0;
        end
        else
        begin : g_mid_r
            assign rw = w_arr[i+1];
            assign re = e_arr[i+1];
            assign rv = v_arr[i+1];
        end

        hpq_cell #(
            .WeightBits(WeightBits)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_weight  (new_weight),
            .left_weight (lw),
            .left_entry  (le),
            .left_valid  (lv),
            .left_open   (lo),
            .right_weight(rw),
            .right_entry (re),
            .right_valid (rv),
            .head_weight (w_arr[0]),
            .head_entry  (e_arr[0]),
            .cell_weight (w_arr[i]),
            .cell_entry  (e_arr[i]),
            .cell_valid  (v_arr[i]),
            .cell_open   (o_arr[i])
        );
    end

endmodule

@@ rtl/core/huffman_min_priority_queue.sv @@
// Insert, pop-minimum and delete-by-symbol: one result per item, in the cycle after the last step.
// Insert, pop and unused codes: done in the cycle after accept, a new item every cycle.
// Delete: busy as each stored entry meets the head (first match pops, rest rotate); done as busy falls.
// The delete length is set by the single head port that every entry must pass through.
// Reset clears every cell's valid bit and the count at once; no clearing pass.
// Results pulse on done for one cycle; the receiver cannot stall.
module huffman_min_priority_queue #(
    parameter int CAPACITY    = 512,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        cmd,
    input  logic [hpq_pkg::OUT_W_BITS-1:0]    weight,
    input  logic [hpq_pkg::SYMBOL_BITS-1:0]   symbol,
    input  logic [hpq_pkg::TAG_BITS-1:0]      tag,
    output logic                              done,
    output logic [hpq_pkg::OUT_W_BITS-1:0]    out_weight,
    output logic [hpq_pkg::SYMBOL_BITS-1:0]   out_symbol,
    output logic [hpq_pkg::TAG_BITS-1:0]      out_tag,
    output logic [1:0]                        status,
    output logic [hpq_pkg::FILL_BITS-1:0]     fill
);

    localparam int KeepBits = (WEIGHT_BITS < hpq_pkg::OUT_W_BITS)
                              ? WEIGHT_BITS : hpq_pkg::OUT_W_BITS;
    localparam int CntW     = $clog2(CAPACITY + 1);
    localparam logic [CntW-1:0] CapCount = CntW'(CAPACITY);
    localparam logic [CntW-1:0] OneCount = CntW'(1);

    hpq_pkg::state_t                 state_reg, state_next;
    logic [CntW-1:0]                 count_reg, count_next;
    logic [CntW-1:0]                 remain_reg, remain_next;
    logic                            found_reg, found_next;
    logic [hpq_pkg::SYMBOL_BITS-1:0] key_reg, key_next;
    logic                            done_reg, done_next;
    logic [hpq_pkg::OUT_W_BITS-1:0]  out_weight_reg, out_weight_next;
    logic [hpq_pkg::SYMBOL_BITS-1:0] out_symbol_reg, out_symbol_next;
    logic [hpq_pkg::TAG_BITS-1:0]    out_tag_reg, out_tag_next;
    hpq_pkg::status_t                status_reg, status_next;
    logic [hpq_pkg::FILL_BITS-1:0]   fill_reg, fill_next;

    hpq_pkg::ctrl_t                  ctrl;
    logic [KeepBits-1:0]             new_weight;
    logic [KeepBits-1:0]             head_weight;
    hpq_pkg::entry_t                 head_entry;
    logic [63:0]                     head_w_wide;
    logic [CntW+hpq_pkg::FILL_BITS-1:0] count_wide;
    logic                            head_hit;

    assign new_weight  = weight[KeepBits-1:0];
    assign head_w_wide = 64'(head_weight);
    assign head_hit    = (head_entry.symbol == key_reg);
    assign count_wide  = {{hpq_pkg::FILL_BITS{1'b0}}, count_next};

    hpq_chain #(
        .Capacity  (CAPACITY),
        .WeightBits(KeepBits)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_weight (new_weight),
        .head_weight(head_weight),
        .head_entry (head_entry)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        found_next      = found_reg;
        key_next        = key_reg;
        done_next       = 1'b0;
        out_weight_next = out_weight_reg;
        out_symbol_next = out_symbol_reg;
        out_tag_next    = out_tag_reg;
        status_next     = status_reg;
        ctrl.op         = hpq_pkg::OP_HOLD;
        ctrl.symbol     = symbol;
        ctrl.tag        = tag;

        unique case (state_reg)
            hpq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    out_weight_next = '0;
                    out_symbol_next = '0;
                    out_tag_next    = '0;
                    status_next     = hpq_pkg::STAT_OK;
                    done_next       = 1'b1;
                    unique case (hpq_pkg::cmd_t'(cmd))
                        hpq_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CapCount)
                            begin
                                status_next = hpq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctrl.op    = hpq_pkg::OP_INSERT;
                                count_next = count_reg + OneCount;
                            end
                        end
                        hpq_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = hpq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.op         = hpq_pkg::OP_POP;
                                count_next      = count_reg - OneCount;
                                out_weight_next = head_w_wide[hpq_pkg::OUT_W_BITS-1:0];
                                out_symbol_next = head_entry.symbol;
                                out_tag_next    = head_entry.tag;
                            end
                        end
                        hpq_pkg::CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = hpq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                done_next   = 1'b0;
                                state_next  = hpq_pkg::ST_SCAN;
                                remain_next = count_reg;
                                found_next  = 1'b0;
                                key_next    = symbol;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            hpq_pkg::ST_SCAN:
            begin
                // each cycle the head either leaves (first match) or wraps to the tail
                if (!found_reg && head_hit)
                begin
                    ctrl.op         = hpq_pkg::OP_POP;
                    found_next      = 1'b1;
                    count_next      = count_reg - OneCount;
                    out_weight_next = head_w_wide[hpq_pkg::OUT_W_BITS-1:0];
                    out_symbol_next = head_entry.symbol;
                    out_tag_next    = head_entry.tag;
                end
                else
                begin
                    ctrl.op = hpq_pkg::OP_ROTATE;
                end
                remain_next = remain_reg - OneCount;
                if (remain_reg == OneCount)
                begin
                    state_next  = hpq_pkg::ST_IDLE;
                    done_next   = 1'b1;
                    status_next = found_next ? hpq_pkg::STAT_OK : hpq_pkg::STAT_NOTFOUND;
                end
            end
        endcase

        fill_next = count_wide[hpq_pkg::FILL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hpq_pkg::ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        out_weight_reg <= out_weight_next;
        out_symbol_reg <= out_symbol_next;
        out_tag_reg    <= out_tag_next;
        status_reg     <= status_next;
        fill_reg       <= fill_next;
    end

    assign busy       = (state_reg != hpq_pkg::ST_IDLE);
    assign done       = done_reg;
    assign out_weight = out_weight_reg;
    assign out_symbol = out_symbol_reg;
    assign out_tag    = out_tag_reg;
    assign status     = status_reg;
    assign fill       = fill_reg;

endmodule

@@ tb/huffman_min_priority_queue_tb.sv @@
// Self-checking testbench for the sorted Huffman node priority queue.
`timescale 1ns / 1ps

module huffman_min_priority_queue_tb;
    import hpq_pkg::*;

    localparam int CAPACITY    = 512;
    localparam int WEIGHT_BITS = 32;
    localparam logic [31:0] WEIGHT_MASK =
        (WEIGHT_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WEIGHT_BITS) - 32'd1);
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] weight;
        logic [7:0]  symbol;
        logic [8:0]  tag;
    } node_t;

    typedef struct packed {
        logic [31:0] weight;
        logic [7:0]  symbol;
        logic [8:0]  tag;
        logic [1:0]  status;
        logic [9:0]  fill;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [31:0] weight;
    logic [7:0]  symbol;
    logic [8:0]  tag;
    logic        done;
    logic [31:0] out_weight;
    logic [7:0]  out_symbol;
    logic [8:0]  out_tag;
    logic [1:0]  status;
    logic [9:0]  fill;

    node_t  shadow_nodes[$];     // sorted contents the block should hold
    reply_t pending_replies[$];  // replies owed by the block, oldest first
    int     errors = 0;
    int     burst_left = 0;
    bit     gaps_on = 1'b1;

    huffman_min_priority_queue #(
        .CAPACITY    (CAPACITY),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .weight     (weight),
        .symbol     (symbol),
        .tag        (tag),
        .done       (done),
        .out_weight (out_weight),
        .out_symbol (out_symbol),
        .out_tag    (out_tag),
        .status     (status),
        .fill       (fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Apply one command to the shadow queue and return the reply it owes.
    function automatic reply_t shadow_apply(logic [1:0] c, logic [31:0] w_in,
                                            logic [7:0] s, logic [8:0] t);
        reply_t r;
        node_t  n;
        int     pos;
        logic [31:0] w;
        r = '0;
        r.status = STAT_OK;
        w = w_in & WEIGHT_MASK;
        if (c == CMD_INSERT)
        begin
            if (shadow_nodes.size() >= CAPACITY)
                r.status = STAT_FULL;
            else
            begin
                pos = shadow_nodes.size();
                for (int i = 0; i < shadow_nodes.size(); i++)
                begin
                    if (w < shadow_nodes[i].weight ||
                        (w == shadow_nodes[i].weight && s > shadow_nodes[i].symbol))
                    begin
                        pos = i;
                        break;
                    end
                end
                n.weight = w;
                n.symbol = s;
                n.tag    = t;
                shadow_nodes.insert(pos, n);
            end
        end
        else if (c == CMD_POP || c == CMD_DELETE)
        begin
            if (shadow_nodes.size() == 0)
                r.status = STAT_EMPTY;
            else
            begin
                pos = (c == CMD_POP) ? 0 : -1;
                if (c == CMD_DELETE)
                begin
                    for (int i = 0; i < shadow_nodes.size(); i++)
                    begin
                        if (shadow_nodes[i].symbol == s)
                        begin
                            pos = i;
                            break;
                        end
                    end
                end
                if (pos < 0)
                    r.status = STAT_NOTFOUND;
                else
                begin
                    r.weight = shadow_nodes[pos].weight;
                    r.symbol = shadow_nodes[pos].symbol;
                    r.tag    = shadow_nodes[pos].tag;
                    shadow_nodes.delete(pos);
                end
            end
        end
        r.fill = 10'(shadow_nodes.size());
        return r;
    endfunction

    // Result checker: the block cannot be held off, so every done is taken.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("reply with no item outstanding");
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (out_weight !== want.weight)
                begin
                    $error("out_weight: expected %h, got %h", want.weight, out_weight);
                    errors++;
                end
                if (out_symbol !== want.symbol)
                begin
                    $error("out_symbol: expected %h, got %h", want.symbol, out_symbol);
                    errors++;
                end
                if (out_tag !== want.tag)
                begin
                    $error("out_tag: expected %h, got %h", want.tag, out_tag);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (fill !== want.fill)
                begin
                    $error("fill: expected %0d, got %0d", want.fill, fill);
                    errors++;
                end
            end
        end
    end

    // Drive one item and hold it until the block takes it.
    task automatic send_item(logic [1:0] c, logic [31:0] w, logic [7:0] s, logic [8:0] t);
        @(negedge clk);
        start  <= 1'b1;
        cmd    <= c;
        weight <= w;
        symbol <= s;
        tag    <= t;
        do
            @(posedge clk);
        while (busy);
        pending_replies.push_back(shadow_apply(c, w, s, t));
    endtask

    task automatic idle_cycles(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_all_replies();
        @(negedge clk);
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            if (gaps_on)
                idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    function automatic logic [1:0] pick_cmd(int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            return CMD_INSERT;
        else if (r >= 97)
            return CMD_UNUSED;
        else if (r % 2)
            return CMD_POP;
        else
            return CMD_DELETE;
    endfunction

    // Biased toward ties and stored values so sort and search paths get exercised.
    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 4))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 15);
            3:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default:
                if (shadow_nodes.size() != 0)
                    return shadow_nodes[$urandom_range(0, shadow_nodes.size() - 1)].weight;
                else
                    return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_symbol();
        logic [7:0] edge_sym;
        edge_sym = 8'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return edge_sym[2] ? (8'd252 + edge_sym[1:0]) : {6'd0, edge_sym[1:0]};
            default:
                if (shadow_nodes.size() != 0)
                    return shadow_nodes[$urandom_range(0, shadow_nodes.size() - 1)].symbol;
                else
                    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_item(int insert_pct);
        logic [1:0] c;
        c = pick_cmd(insert_pct);
        send_item(c, pick_weight(), pick_symbol(), 9'($urandom_range(0, 511)));
    endtask

    task automatic test_empty_store();
        send_item(CMD_POP, 32'hFFFF_FFFF, 8'hFF, 9'h1FF);
        send_item(CMD_DELETE, 32'h0, 8'h00, 9'h000);
        send_item(CMD_DELETE, 32'h0, 8'hFF, 9'h000);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 9'h1FF);
        wait_all_replies();
    endtask

    task automatic test_sort_order();
        send_item(CMD_INSERT, 32'd5, 8'd3, 9'd1);
        send_item(CMD_INSERT, 32'd5, 8'd200, 9'd2);      // higher symbol goes first
        send_item(CMD_INSERT, 32'd5, 8'd3, 9'd511);      // duplicate lands after
        send_item(CMD_INSERT, 32'h0, 8'h00, 9'h000);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 9'h1FF);
        send_item(CMD_INSERT, 32'd5, 8'd255, 9'd3);
        send_item(CMD_UNUSED, 32'h1234_5678, 8'h9A, 9'h0BC);
        send_item(CMD_DELETE, 32'h0, 8'd77, 9'h000);     // absent symbol
        send_item(CMD_DELETE, 32'h0, 8'd3, 9'h000);      // first of the duplicates
        send_item(CMD_DELETE, 32'h0, 8'd3, 9'h000);
        send_item(CMD_POP, 32'h0, 8'h00, 9'h000);
        send_item(CMD_POP, 32'h0, 8'h00, 9'h000);
        send_item(CMD_INSERT, 32'hAAAA_AAAA, 8'h55, 9'h155);
        send_item(CMD_INSERT, 32'h5555_5555, 8'hAA, 9'h0AA);
        send_item(CMD_DELETE, 32'h0, 8'hFF, 9'h000);
        send_item(CMD_POP, 32'h0, 8'h00, 9'h000);
        send_item(CMD_POP, 32'h0, 8'h00, 9'h000);
        send_item(CMD_POP, 32'h0, 8'h00, 9'h000);
        send_item(CMD_POP, 32'h0, 8'h00, 9'h000);        // empty again
        wait_all_replies();
    endtask

    task automatic test_random_mixed(int n);
        int ins;
        for (int i = 0; i < n; i++)
        begin
            gaps_on = ((i / 50) % 2) == 0;
            if (i == n / 2)
                wait_all_replies();
            pace_sender();
            ins = (shadow_nodes.size() < 4) ? 70 : (shadow_nodes.size() > 40) ? 25 : 45;
            random_item(ins);
        end
        gaps_on = 1'b1;
        wait_all_replies();
    endtask

    task automatic test_fill_to_capacity();
        while (shadow_nodes.size() < CAPACITY)
        begin
            pace_sender();
            random_item(92);
        end
        send_item(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)),
                  9'($urandom_range(0, 511)));
        send_item(CMD_POP, 32'h0, 8'h00, 9'h000);
        send_item(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)),
                  9'($urandom_range(0, 511)));
        send_item(CMD_INSERT, 32'h0, 8'hFF, 9'h1FF);
        send_item(CMD_DELETE, 32'h0, pick_symbol(), 9'h000);
        wait_all_replies();
    endtask

    task automatic test_high_fill_mix(int n);
        for (int i = 0; i < n; i++)
        begin
            pace_sender();
            random_item(20);
        end
        wait_all_replies();
    endtask

    initial
    begin
        rst_n  = 1'b0;
        start  = 1'b0;
        cmd    = CMD_INSERT;
        weight = '0;
        symbol = '0;
        tag    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_sort_order();
        test_random_mixed(350);
        test_fill_to_capacity();
        test_high_fill_mix(100);

        wait_all_replies();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ huffman_min_priority_queue.f @@
rtl/core/hpq_pkg.sv
rtl/core/hpq_cell.sv
rtl/core/hpq_chain.sv
rtl/core/huffman_min_priority_queue.sv
tb/huffman_min_priority_queue_tb.sv
